>>> rtl/asdbw_pkg.sv
package asdbw_pkg;

  localparam int CH_W = 4;
  localparam int QUEUE_DEPTH = 2;
  localparam logic [9:0] CODE_BIAS = 10'h1FF;
  localparam int BIAS_SHIFT = 6;

  typedef enum logic [2:0] {
    CFG_CAPTURE_ENABLE       = 3'd0,
    CFG_SAMPLE_16BIT         = 3'd1,
    CFG_LAST_CHANNEL         = 3'd2,
    CFG_WINDOW_LOG2          = 3'd3,
    CFG_CHANNEL_BUFFER_BYTES = 3'd4,
    CFG_SECOND_BUFFER_BASE   = 3'd5,
    CFG_CHANNEL_MUX_TABLE    = 3'd6
  } cfg_idx_e;

  typedef enum logic [1:0] {
    OP_SAMPLE,
    OP_RELEASE_FIRST,
    OP_RELEASE_SECOND
  } op_e;

  typedef struct packed {
    logic       req_type;
    logic [9:0] adc_code;
    logic       release_half;
  } in_item_t;

  typedef struct packed {
    logic        write_valid;
    logic [15:0] write_addr;
    logic [15:0] write_data;
    logic        write_two_bytes;
    logic [2:0]  mux_select;
    logic        first_half_full;
    logic        second_half_full;
    logic        channel_error;
    logic [31:0] samples_collected;
  } out_item_t;

  typedef struct packed {
    logic        capture_enable;
    logic        sample_16bit;
    logic [3:0]  last_channel;
    logic [3:0]  window_log2;
    logic [15:0] channel_buffer_bytes;
    logic [15:0] second_buffer_base;
    logic [63:0] channel_mux_table;
  } cfg_t;

  typedef struct packed {
    op_e         op;
    logic [7:0]  byte8;
    logic [15:0] word16;
  } task_t;

  function automatic logic [3:0] mux_entry(input logic [63:0] tbl, input logic [CH_W-1:0] ch);
    mux_entry = tbl[ch*4 +: 4];
  endfunction

endpackage

>>> rtl/asdbw_front.sv
module asdbw_front (
  input  logic                in_valid,
  output logic                in_stall,
  input  asdbw_pkg::in_item_t in_item,
  output logic                q_push,
  output asdbw_pkg::task_t    q_task,
  input  logic                q_full
);
  import asdbw_pkg::*;

  logic [9:0] biased;

  assign in_stall = q_full;
  assign q_push   = in_valid && !q_full;
  assign biased   = in_item.adc_code - CODE_BIAS;

  always_comb begin
    q_task.byte8  = in_item.adc_code[9:2];
    q_task.word16 = 16'(biased) << BIAS_SHIFT;
    priority if (!in_item.req_type) begin
      q_task.op = OP_SAMPLE;
    end else if (!in_item.release_half) begin
      q_task.op = OP_RELEASE_FIRST;
    end else begin
      q_task.op = OP_RELEASE_SECOND;
    end
  end

endmodule

>>> rtl/asdbw_queue.sv
module asdbw_queue (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  asdbw_pkg::task_t push_task,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output asdbw_pkg::task_t head
);
  import asdbw_pkg::*;

  localparam int PTR_W = $clog2(QUEUE_DEPTH);
  localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

  task_t            mem_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r;
  logic [PTR_W-1:0] rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic [CNT_W-1:0] count_nxt;

  assign full  = (count_r == CNT_W'(QUEUE_DEPTH));
  assign valid = (count_r != '0);
  assign head  = mem_r[rd_ptr_r];

  always_comb begin
    count_nxt = count_r;
    if (push && !pop) begin
      count_nxt = count_r + CNT_W'(1);
    end else if (pop && !push) begin
      count_nxt = count_r - CNT_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      count_r <= count_nxt;
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wr_ptr_r] <= push_task;
    end
  end

endmodule

>>> rtl/asdbw_back.sv
module asdbw_back #(
  parameter int MAX_CHANNELS = 16,
  parameter int ADDR_WIDTH   = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  asdbw_pkg::cfg_t      cfg,
  input  logic                 q_valid,
  input  asdbw_pkg::task_t     q_task,
  output logic                 q_pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output asdbw_pkg::out_item_t out_item
);
  import asdbw_pkg::*;

  localparam logic [CH_W-1:0] TOP_MAX = CH_W'(MAX_CHANNELS - 1);
  localparam int AW_EFF = (ADDR_WIDTH < 16) ? ADDR_WIDTH : 16;
  localparam logic [15:0] ADDR_MASK = 16'((33'd1 << AW_EFF) - 33'd1);

  logic [CH_W-1:0] chan_r, chan_nxt;
  logic [15:0]     off_r, off_nxt;
  logic            first_r, first_nxt;
  logic            ffull_r, ffull_nxt;
  logic            sfull_r, sfull_nxt;
  logic            err_r, err_nxt;
  logic [31:0]     count_r, count_nxt;
  logic            out_valid_r;
  out_item_t       out_r, out_nxt;

  logic [CH_W-1:0] top;
  logic [CH_W-1:0] chan_a;
  logic [15:0]     off_a;
  logic [15:0]     base;
  logic [19:0]     prod;
  logic [19:0]     addr_full;
  logic [15:0]     window;
  logic [15:0]     win_mask;
  logic            do_write;
  logic [3:0]      nxt_entry;

  assign q_pop     = q_valid && (!out_valid_r || !out_stall);
  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  assign top       = (cfg.last_channel > TOP_MAX) ? TOP_MAX : cfg.last_channel;
  assign base      = first_r ? 16'd0 : cfg.second_buffer_base;
  assign prod      = 20'(chan_r) * 20'(cfg.channel_buffer_bytes);
  assign addr_full = {4'b0, base} + prod + {4'b0, off_r};
  assign window    = 16'd1 << cfg.window_log2;
  assign win_mask  = window - 16'd1;
  assign do_write  = (q_task.op == OP_SAMPLE) && cfg.capture_enable
                     && !(ffull_r && sfull_r) && !err_r;

  always_comb begin
    chan_nxt  = chan_r;
    off_nxt   = off_r;
    first_nxt = first_r;
    ffull_nxt = ffull_r;
    sfull_nxt = sfull_r;
    err_nxt   = err_r;
    count_nxt = count_r;
    chan_a    = chan_r;
    off_a     = off_r;
    out_nxt   = '0;
    nxt_entry = '0;

    unique case (q_task.op)
      OP_RELEASE_FIRST:  ffull_nxt = 1'b0;
      OP_RELEASE_SECOND: sfull_nxt = 1'b0;
      default: begin
        if (do_write) begin
          out_nxt.write_valid     = 1'b1;
          out_nxt.write_addr      = addr_full[15:0] & ADDR_MASK;
          out_nxt.write_two_bytes = cfg.sample_16bit;
          out_nxt.write_data      = cfg.sample_16bit ? q_task.word16 : {8'b0, q_task.byte8};
          off_a     = off_r + (cfg.sample_16bit ? 16'd2 : 16'd1);
          count_nxt = count_r + 32'd1;
          if (off_a == cfg.channel_buffer_bytes && chan_r == top) begin
            if (first_r) begin
              ffull_nxt = 1'b1;
            end else begin
              sfull_nxt = 1'b1;
            end
            first_nxt = !first_r;
            off_a     = '0;
            chan_a    = '0;
          end
          chan_nxt = chan_a;
          off_nxt  = off_a;
          if (top != '0 && off_a != '0 && (off_a & win_mask) == '0) begin
            if (chan_a >= top) begin
              chan_nxt = '0;
            end else begin
              chan_nxt = chan_a + CH_W'(1);
              off_nxt  = off_a - window;
            end
            nxt_entry = mux_entry(cfg.channel_mux_table, chan_nxt);
            if (nxt_entry[3]) begin
              err_nxt = 1'b1;
            end
          end
        end
      end
    endcase

    nxt_entry                 = mux_entry(cfg.channel_mux_table, chan_nxt);
    out_nxt.mux_select        = nxt_entry[2:0];
    out_nxt.first_half_full   = ffull_nxt;
    out_nxt.second_half_full  = sfull_nxt;
    out_nxt.channel_error     = err_nxt;
    out_nxt.samples_collected = count_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      chan_r      <= '0;
      off_r       <= '0;
      first_r     <= 1'b1;
      ffull_r     <= 1'b0;
      sfull_r     <= 1'b0;
      err_r       <= 1'b0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      if (q_pop) begin
        chan_r  <= chan_nxt;
        off_r   <= off_nxt;
        first_r <= first_nxt;
        ffull_r <= ffull_nxt;
        sfull_r <= sfull_nxt;
        err_r   <= err_nxt;
        count_r <= count_nxt;
      end
      if (q_pop) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      out_r <= out_nxt;
    end
  end

  // The channel error flag is sticky until reset.
  a_err_sticky: assert property (@(posedge clk) disable iff (!rst_n)
    err_r |=> err_r)
    else $error("channel error flag cleared without reset");

  // The active half only flips on a sample transaction that was written.
  a_half_flip: assert property (@(posedge clk) disable iff (!rst_n)
    (!$stable(first_r) && $past(rst_n)) |->
      $past(q_pop && do_write && q_task.op == OP_SAMPLE))
    else $error("active half changed without a write");

  // The sample counter moves only together with a freshly loaded write result.
  a_count_write: assert property (@(posedge clk) disable iff (!rst_n)
    (!$stable(count_r) && $past(rst_n)) |-> (out_valid_r && out_r.write_valid))
    else $error("sample count changed without a written result");

endmodule

>>> rtl/adc_scan_double_buffer_writer.sv
// ADC scan writer with a double buffer. Each transaction on the input channel is either
// a 10-bit conversion or the release of one buffer half, and each one produces exactly
// one result transaction carrying the buffer write (if any) and the status flags after
// the update. The block sustains one transaction per clock cycle in both directions while
// the result side does not stall; a transaction is written into the two-entry queue
// behind the input decoder, and the state update then loads its result into the result
// register. While the result side stalls the queue fills and the input stalls; the
// input resumes once a queue entry is freed. The address is computed combinationally
// as half base plus channel times sub-buffer size plus offset. Configuration registers
// may be written only while no transaction is in flight.
module adc_scan_double_buffer_writer #(
  parameter int MAX_CHANNELS = 16,
  parameter int ADDR_WIDTH   = 16
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  asdbw_pkg::in_item_t  in_item,
  output logic                 out_valid,
  input  logic                 out_stall,
  output asdbw_pkg::out_item_t out_item,
  input  logic                 cfg_wr_en,
  input  logic [2:0]           cfg_index,
  input  logic [63:0]          cfg_data
);
  import asdbw_pkg::*;

  cfg_t  cfg_r;
  logic  q_push;
  task_t q_push_task;
  logic  q_full;
  logic  q_pop;
  logic  q_valid;
  task_t q_head;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.capture_enable       <= 1'b0;
      cfg_r.sample_16bit         <= 1'b0;
      cfg_r.last_channel         <= '0;
      cfg_r.window_log2          <= '0;
      cfg_r.channel_buffer_bytes <= 16'd512;
      cfg_r.second_buffer_base   <= 16'd8192;
      cfg_r.channel_mux_table    <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_idx_e'(cfg_index))
        CFG_CAPTURE_ENABLE:       cfg_r.capture_enable       <= cfg_data[0];
        CFG_SAMPLE_16BIT:         cfg_r.sample_16bit         <= cfg_data[0];
        CFG_LAST_CHANNEL:         cfg_r.last_channel         <= cfg_data[3:0];
        CFG_WINDOW_LOG2:          cfg_r.window_log2          <= cfg_data[3:0];
        CFG_CHANNEL_BUFFER_BYTES: cfg_r.channel_buffer_bytes <= cfg_data[15:0];
        CFG_SECOND_BUFFER_BASE:   cfg_r.second_buffer_base   <= cfg_data[15:0];
        CFG_CHANNEL_MUX_TABLE:    cfg_r.channel_mux_table    <= cfg_data;
        default: begin
        end
      endcase
    end
  end

  asdbw_front u_front (
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .q_push   (q_push),
    .q_task   (q_push_task),
    .q_full   (q_full)
  );

  asdbw_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_task (q_push_task),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  asdbw_back #(
    .MAX_CHANNELS (MAX_CHANNELS),
    .ADDR_WIDTH   (ADDR_WIDTH)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .q_valid   (q_valid),
    .q_task    (q_head),
    .q_pop     (q_pop),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

>>> verif/tb.sv
`timescale 1ns / 1ps

module tb;
  import asdbw_pkg::*;

  localparam logic REQ_SAMPLE  = 1'b0;
  localparam logic REQ_RELEASE = 1'b1;
  localparam logic HALF_FIRST  = 1'b0;
  localparam logic HALF_SECOND = 1'b1;
  localparam logic [15:0] ADC_MIDSCALE = 16'h01FF;
  localparam int WIDE_SHIFT  = 6;
  localparam int LONG_HOLD   = 80;
  localparam int QUIET_LIMIT = 2000;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_stall;
  in_item_t    in_item = '0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  out_item_t   out_item;
  logic        cfg_wr_en = 1'b0;
  logic [2:0]  cfg_index = '0;
  logic [63:0] cfg_data = '0;
  logic        hold_trigger = 1'b0;

  adc_scan_double_buffer_writer u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_item (out_item),
    .cfg_wr_en(cfg_wr_en),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // Shadow copy of the register file.
  logic        m_capture;
  logic        m_wide;
  logic [3:0]  m_last_ch;
  logic [3:0]  m_win_log2;
  logic [15:0] m_chan_bytes;
  logic [15:0] m_half2_base;
  logic [63:0] m_mux_tbl;

  // Shadow copy of the scan state.
  logic [3:0]  s_chan;
  logic [15:0] s_offset;
  logic        s_in_first;
  logic        s_first_full;
  logic        s_second_full;
  logic        s_err;
  logic [31:0] s_count;

  in_item_t  conv_queue[$];
  out_item_t expected_writes[$];
  out_item_t predicted;
  out_item_t want;
  bit        idle_on = 1'b1;
  int        send_gap;
  int        recv_hold;
  int        quiet_cycles = 0;
  int        fail_count = 0;
  int        n_in = 0;
  int        n_out = 0;
  int        n_writes = 0;
  int        n_setups = 0;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic out_item_t predict_scan_write(input in_item_t req);
    out_item_t   r;
    logic [31:0] addr;
    logic [15:0] win;
    r = '0;
    if (req.req_type == REQ_RELEASE) begin
      if (req.release_half == HALF_FIRST) s_first_full = 1'b0;
      else s_second_full = 1'b0;
    end else if (m_capture && !(s_first_full && s_second_full) && !s_err) begin
      addr = (s_in_first ? 32'd0 : 32'(m_half2_base)) + 32'(s_chan) * 32'(m_chan_bytes)
             + 32'(s_offset);
      win = 16'd1 << m_win_log2;
      r.write_valid = 1'b1;
      r.write_addr = addr[15:0];
      if (m_wide) begin
        r.write_data = (16'(req.adc_code) - ADC_MIDSCALE) << WIDE_SHIFT;
        r.write_two_bytes = 1'b1;
        s_offset = s_offset + 16'd2;
      end else begin
        r.write_data = 16'(req.adc_code >> 2);
        s_offset = s_offset + 16'd1;
      end
      s_count = s_count + 32'd1;
      if (s_offset == m_chan_bytes && s_chan == m_last_ch) begin
        if (s_in_first) s_first_full = 1'b1;
        else s_second_full = 1'b1;
        s_in_first = !s_in_first;
        s_offset = '0;
        s_chan = '0;
      end
      if (m_last_ch != 0 && s_offset != 0 && (s_offset & (win - 16'd1)) == 16'd0) begin
        if (s_chan >= m_last_ch) begin
          s_chan = '0;
        end else begin
          s_chan = s_chan + 4'd1;
          s_offset = s_offset - win;
        end
        if (m_mux_tbl[{s_chan, 2'd3}]) s_err = 1'b1;
      end
    end
    r.mux_select = m_mux_tbl[{s_chan, 2'd0} +: 3];
    r.first_half_full = s_first_full;
    r.second_half_full = s_second_full;
    r.channel_error = s_err;
    r.samples_collected = s_count;
    return r;
  endfunction

  function automatic in_item_t rand_item(input int rel_pct);
    in_item_t it;
    it.req_type = ($urandom_range(0, 99) < rel_pct) ? REQ_RELEASE : REQ_SAMPLE;
    it.adc_code = 10'($urandom_range(0, 1023));
    it.release_half = $urandom_range(0, 1) ? HALF_SECOND : HALF_FIRST;
    return it;
  endfunction

  function automatic logic [63:0] valid_mux_table(input logic [3:0] top);
    logic [63:0] t;
    t = {$urandom, $urandom};
    for (int c = 0; c <= top; c++) t[c * 4 + 3] = 1'b0;
    return t;
  endfunction

  task automatic queue_req(input logic rt, input logic [9:0] code, input logic half);
    in_item_t it;
    it.req_type = rt;
    it.adc_code = code;
    it.release_half = half;
    conv_queue.push_back(it);
  endtask

  // The check runs at the falling edge, after every update of the rising edge.
  task automatic drain();
    do begin
      @(negedge clk);
    end while (conv_queue.size() != 0 || in_valid || expected_writes.size() != 0);
    repeat (6) @(posedge clk);
  endtask

  task automatic set_reg(input cfg_idx_e idx, input logic [63:0] val);
    @(posedge clk);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      CFG_CAPTURE_ENABLE:       m_capture = val[0];
      CFG_SAMPLE_16BIT:         m_wide = val[0];
      CFG_LAST_CHANNEL:         m_last_ch = val[3:0];
      CFG_WINDOW_LOG2:          m_win_log2 = val[3:0];
      CFG_CHANNEL_BUFFER_BYTES: m_chan_bytes = val[15:0];
      CFG_SECOND_BUFFER_BASE:   m_half2_base = val[15:0];
      CFG_CHANNEL_MUX_TABLE:    m_mux_tbl = val;
      default: ;
    endcase
  endtask

  task automatic program_setup(input logic cap, input logic wide, input logic [3:0] lc,
                               input logic [3:0] wl, input logic [15:0] cbb,
                               input logic [15:0] base, input logic [63:0] tbl);
    drain();
    set_reg(CFG_CAPTURE_ENABLE, 64'(cap));
    set_reg(CFG_SAMPLE_16BIT, 64'(wide));
    set_reg(CFG_LAST_CHANNEL, 64'(lc));
    set_reg(CFG_WINDOW_LOG2, 64'(wl));
    set_reg(CFG_CHANNEL_BUFFER_BYTES, 64'(cbb));
    set_reg(CFG_SECOND_BUFFER_BASE, 64'(base));
    set_reg(CFG_CHANNEL_MUX_TABLE, tbl);
    n_setups++;
  endtask

  // Input driver: each transaction is predicted at the edge where it is accepted.
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        predicted = predict_scan_write(in_item);
        if (predicted.write_valid) n_writes++;
        expected_writes.push_back(predicted);
        n_in++;
      end
      if (!in_valid || !in_stall) begin
        if (send_gap == 0 && idle_on && $urandom_range(0, 7) == 0)
          send_gap = $urandom_range(1, 10);
        if (send_gap > 0) begin
          send_gap--;
          in_valid <= 1'b0;
        end else if (conv_queue.size() > 0) begin
          in_valid <= 1'b1;
          in_item <= conv_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall <= 1'b0;
      recv_hold = 0;
    end else begin
      if (hold_trigger)
        recv_hold = LONG_HOLD;
      else if (recv_hold == 0 && idle_on && $urandom_range(0, 7) == 0)
        recv_hold = $urandom_range(1, 10);
      if (recv_hold > 0) begin
        recv_hold--;
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      n_out++;
      if (expected_writes.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("Result transaction %0d arrived with nothing expected: %h", n_out, out_item);
      end else begin
        want = expected_writes.pop_front();
        if (out_item.write_valid !== want.write_valid ||
            out_item.write_addr !== want.write_addr ||
            out_item.write_data !== want.write_data ||
            out_item.write_two_bytes !== want.write_two_bytes ||
            out_item.mux_select !== want.mux_select ||
            out_item.first_half_full !== want.first_half_full ||
            out_item.second_half_full !== want.second_half_full ||
            out_item.channel_error !== want.channel_error ||
            out_item.samples_collected !== want.samples_collected) begin
          fail_count++;
          if (fail_count <= 10) begin
            $display("Result %0d expected: wr=%0d addr=%h data=%h two=%0d mux=%0d full=%0d%0d err=%0d n=%0d",
                     n_out, want.write_valid, want.write_addr, want.write_data,
                     want.write_two_bytes, want.mux_select, want.first_half_full,
                     want.second_half_full, want.channel_error, want.samples_collected);
            $display("Result %0d actual:   wr=%0d addr=%h data=%h two=%0d mux=%0d full=%0d%0d err=%0d n=%0d",
                     n_out, out_item.write_valid, out_item.write_addr, out_item.write_data,
                     out_item.write_two_bytes, out_item.mux_select, out_item.first_half_full,
                     out_item.second_half_full, out_item.channel_error,
                     out_item.samples_collected);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
      if (quiet_cycles == QUIET_LIMIT) begin
        $display("Timeout: no transaction for %0d cycles, %0d results outstanding",
                 QUIET_LIMIT, expected_writes.size());
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  initial begin
    logic [3:0]  lc;
    logic [3:0]  wl;
    logic [15:0] cbb;
    logic [15:0] base;
    int          rel;
    m_capture = 1'b0;
    m_wide = 1'b0;
    m_last_ch = '0;
    m_win_log2 = '0;
    m_chan_bytes = 16'd512;
    m_half2_base = 16'd8192;
    m_mux_tbl = '0;
    s_chan = '0;
    s_offset = '0;
    s_in_first = 1'b1;
    s_first_full = 1'b0;
    s_second_full = 1'b0;
    s_err = 1'b0;
    s_count = '0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Capture is off after reset, so the sample is dropped.
    queue_req(REQ_SAMPLE, 10'h3FF, HALF_FIRST);
    queue_req(REQ_RELEASE, 10'h000, HALF_FIRST);
    queue_req(REQ_RELEASE, 10'h000, HALF_SECOND);

    // Fill both halves, drop on both full, release, release again with no effect.
    program_setup(1'b1, 1'b0, 4'd0, 4'd0, 16'd4, 16'h0100, 64'h0765_4321_0765_4321);
    queue_req(REQ_SAMPLE, 10'h000, HALF_FIRST);
    queue_req(REQ_SAMPLE, 10'h3FF, HALF_FIRST);
    queue_req(REQ_SAMPLE, 10'h1FF, HALF_FIRST);
    queue_req(REQ_SAMPLE, 10'h200, HALF_FIRST);
    queue_req(REQ_SAMPLE, 10'h003, HALF_FIRST);
    queue_req(REQ_SAMPLE, 10'h3FC, HALF_FIRST);
    queue_req(REQ_SAMPLE, 10'h155, HALF_FIRST);
    queue_req(REQ_SAMPLE, 10'h2AA, HALF_FIRST);
    queue_req(REQ_SAMPLE, 10'h111, HALF_FIRST);
    queue_req(REQ_RELEASE, 10'h000, HALF_SECOND);
    queue_req(REQ_RELEASE, 10'h3FF, HALF_SECOND);
    queue_req(REQ_SAMPLE, 10'h222, HALF_SECOND);

    program_setup(1'b1, 1'b1, 4'd0, 4'd0, 16'd8, 16'h0100, 64'h0765_4321_0765_4321);
    queue_req(REQ_SAMPLE, 10'h000, HALF_FIRST);
    queue_req(REQ_SAMPLE, 10'h3FF, HALF_FIRST);
    queue_req(REQ_SAMPLE, 10'h1FF, HALF_FIRST);
    queue_req(REQ_SAMPLE, 10'h200, HALF_FIRST);

    // Channel rotation through three channels with a window of two bytes.
    program_setup(1'b1, 1'b0, 4'd2, 4'd1, 16'd2, 16'h0100, 64'h0765_4321_0765_4321);
    for (int i = 0; i < 6; i++) queue_req(REQ_SAMPLE, 10'($urandom_range(0, 1023)), HALF_FIRST);

    for (int p = 0; p < 18; p++) begin
      case (p)
        0: begin
          lc = 4'd15;
          wl = 4'd15;
          cbb = 16'hFFFF;
          base = 16'hFFFF;
        end
        1: begin
          lc = 4'd0;
          wl = 4'd0;
          cbb = 16'd1;
          base = 16'h0000;
        end
        default: begin
          lc = ($urandom_range(0, 3) == 0) ? 4'($urandom_range(0, 15)) : 4'($urandom_range(0, 3));
          wl = 4'($urandom_range(0, 3));
          cbb = (16'd1 << wl) * 16'($urandom_range(1, 4));
          base = 16'($urandom);
        end
      endcase
      program_setup((p % 7) != 6, 1'($urandom_range(0, 1)), lc, wl, cbb, base,
                    valid_mux_table(lc));
      idle_on = (p != 5);
      rel = $urandom_range(5, 30);
      for (int i = 0; i < 100; i++) conv_queue.push_back(rand_item(rel));
      if (p == 2) begin
        hold_trigger <= 1'b1;
        @(posedge clk);
        hold_trigger <= 1'b0;
      end
    end

    // Wide samples into an odd-sized sub-buffer: the offset steps past the end.
    program_setup(1'b1, 1'b1, 4'd0, 4'd0, 16'd3, 16'h8000, valid_mux_table(4'd0));
    idle_on = 1'b0;
    for (int i = 0; i < 100; i++) queue_req(REQ_SAMPLE, 10'($urandom_range(0, 1023)), HALF_FIRST);

    // Every mux entry marked invalid: the first channel switch sets the sticky error.
    program_setup(1'b1, 1'b0, 4'd3, 4'd0, 16'd4, 16'h0040, '1);
    for (int i = 0; i < 4; i++) queue_req(REQ_SAMPLE, 10'($urandom_range(0, 1023)), HALF_FIRST);
    queue_req(REQ_RELEASE, 10'h000, HALF_FIRST);
    queue_req(REQ_RELEASE, 10'h000, HALF_SECOND);
    for (int i = 0; i < 24; i++) conv_queue.push_back(rand_item(20));

    drain();
    $display("Run covered %0d input transactions over %0d register setups.", n_in, n_setups);
    $display("Checked %0d result transactions, %0d of them buffer writes.", n_out, n_writes);
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("%0d failures", fail_count);
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule

>>> adc_scan_double_buffer_writer.f
rtl/asdbw_pkg.sv
rtl/asdbw_front.sv
rtl/asdbw_queue.sv
rtl/asdbw_back.sv
rtl/adc_scan_double_buffer_writer.sv
verif/tb.sv
